// ===== hdl/quaternion_rotate_vector_assert.svh =====
// Assertion macros shared by the verification code of the quaternion rotator.
`ifndef QUATERNION_ROTATE_VECTOR_ASSERT_SVH
`define QUATERNION_ROTATE_VECTOR_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define QRV_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define QRV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is also checked through reset.
`define QRV_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/qrv_pkg.sv =====
package qrv_pkg;

  // Vector components, used as array indexes.
  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned AX_X     = 0;
  localparam int unsigned AX_Y     = 1;
  localparam int unsigned AX_Z     = 2;

  // Register stages between the input and the output port.
  localparam int unsigned NUM_STAGES = 5;

endpackage

// ===== hdl/qrv_round_sat.sv =====
// Round half up on a fixed binary point, then clamp to the output range.
module qrv_round_sat #(
  parameter int unsigned COMP_WIDTH = 16,
  parameter int unsigned SUM_WIDTH  = 50,
  parameter int unsigned SHIFT      = 28
) (
  input  logic signed [SUM_WIDTH-1:0]  sum_i,
  output logic signed [COMP_WIDTH-1:0] rot_o,
  output logic                         clip_o
);

  localparam logic signed [SUM_WIDTH-1:0] MAX_V =
    {{(SUM_WIDTH-COMP_WIDTH+1){1'b0}}, {(COMP_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] MIN_V =
    {{(SUM_WIDTH-COMP_WIDTH+1){1'b1}}, {(COMP_WIDTH-1){1'b0}}};

  logic signed [SUM_WIDTH-1:0] shifted;

  // The half has already been added, so an arithmetic shift gives the floor.
  assign shifted = sum_i >>> SHIFT;

  always_comb begin
    clip_o = 1'b0;
    rot_o  = shifted[COMP_WIDTH-1:0];
    if (shifted > MAX_V) begin
      clip_o = 1'b1;
      rot_o  = MAX_V[COMP_WIDTH-1:0];
    end else if (shifted < MIN_V) begin
      clip_o = 1'b1;
      rot_o  = MIN_V[COMP_WIDTH-1:0];
    end
  end

endmodule

// ===== hdl/quaternion_rotate_vector.sv =====
// Rotates a 3-vector by a fixed-point quaternion, computing q * (v, 0) * conj(q)
// exactly and returning the vector part rounded half up, saturated to the input
// width, with a flag that is set when any component was clamped. The quaternion
// is not normalised, so a non-unit quaternion scales the result by its squared
// norm. The block is a five-stage pipeline: an item passes through the product,
// sum, product, rounded-sum and output registers in that order, and one item
// is accepted in every cycle while the output side keeps up. The rate is set by
// the two rows of twelve multipliers, one per product of each Hamilton product,
// each followed by a register. When the output is stalled, items close up into
// empty stages, so in_ready stays high until every stage holds an item.
module quaternion_rotate_vector
  import qrv_pkg::*;
#(
  parameter int unsigned COMP_WIDTH     = 16,
  parameter int unsigned QUAT_FRAC_BITS = 14
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COMP_WIDTH-1:0] in_quat_x,
  input  logic signed [COMP_WIDTH-1:0] in_quat_y,
  input  logic signed [COMP_WIDTH-1:0] in_quat_z,
  input  logic signed [COMP_WIDTH-1:0] in_quat_w,
  input  logic signed [COMP_WIDTH-1:0] in_vec_x,
  input  logic signed [COMP_WIDTH-1:0] in_vec_y,
  input  logic signed [COMP_WIDTH-1:0] in_vec_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COMP_WIDTH-1:0] out_rot_x,
  output logic signed [COMP_WIDTH-1:0] out_rot_y,
  output logic signed [COMP_WIDTH-1:0] out_rot_z,
  output logic                         out_clipped
);

  // Widths of the intermediate values. A product of two components needs
  // twice the component width; a sum of three such products one bit more.
  // A product of that sum with a component, and the sum of four of those,
  // are sized so that no value can overflow.
  localparam int unsigned CW    = COMP_WIDTH;
  localparam int unsigned QW    = 2 * CW;
  localparam int unsigned PW    = 2 * CW + 1;
  localparam int unsigned MW    = 3 * CW + 1;
  localparam int unsigned SHIFT = 2 * QUAT_FRAC_BITS;
  localparam int unsigned EW    = ((3 * CW + 2) > (SHIFT + 1) ? 3 * CW + 2 : SHIFT + 1) + 1;

  // One half in units of the final shift, for round-half-up.
  localparam logic signed [EW-1:0] HALF =
    {{(EW-SHIFT){1'b0}}, 1'b1, {(SHIFT-1){1'b0}}};

  // Pipeline control. A stage may take a new item when it is empty or when
  // its own item moves on in the same cycle.
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES-1:0] rdy;
  logic [NUM_STAGES-1:0] ld;

  assign rdy[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_ready;
  assign vld_nxt[0]        = rdy[0] ? in_valid : vld_r[0];
  assign ld[0]             = rdy[0] && in_valid;

  for (genvar k = 1; k < NUM_STAGES; k++) begin : g_ctl
    assign vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    assign ld[k]      = rdy[k] && vld_r[k-1];
  end

  for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_rdy
    assign rdy[k] = !vld_r[k] || rdy[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NUM_STAGES-1];

  // Input components gathered into arrays so that each axis can be built
  // from the same pattern with rotated indexes.
  logic signed [CW-1:0] q_in [NUM_AXES];
  logic signed [CW-1:0] v_in [NUM_AXES];

  assign q_in[AX_X] = in_quat_x;
  assign q_in[AX_Y] = in_quat_y;
  assign q_in[AX_Z] = in_quat_z;
  assign v_in[AX_X] = in_vec_x;
  assign v_in[AX_Y] = in_vec_y;
  assign v_in[AX_Z] = in_vec_z;

  // Stage 0: the twelve products of q * (v, 0).
  logic signed [QW-1:0] a_r  [NUM_AXES];
  logic signed [QW-1:0] b_r  [NUM_AXES];
  logic signed [QW-1:0] c_r  [NUM_AXES];
  logic signed [QW-1:0] d_r  [NUM_AXES];
  logic signed [CW-1:0] q0_r [NUM_AXES];
  logic signed [CW-1:0] qw0_r;

  // Stage 1: the product p = q * (v, 0).
  logic signed [PW-1:0] p_r  [NUM_AXES];
  logic signed [PW-1:0] pw_r;
  logic signed [PW-1:0] pw_nxt;
  logic signed [CW-1:0] q1_r [NUM_AXES];
  logic signed [CW-1:0] qw1_r;

  // Stage 2: the twelve products of p * conj(q).
  logic signed [MW-1:0] e_r [NUM_AXES];
  logic signed [MW-1:0] f_r [NUM_AXES];
  logic signed [MW-1:0] g_r [NUM_AXES];
  logic signed [MW-1:0] h_r [NUM_AXES];

  // Stage 3: the vector part of the result with the rounding half added.
  logic signed [EW-1:0] s_r [NUM_AXES];

  // Stage 4: the output register.
  logic signed [CW-1:0] rot_r [NUM_AXES];
  logic [NUM_AXES-1:0]  clip_vec;
  logic                 clip_r;

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
    localparam int unsigned I1 = (i + 1) % NUM_AXES;
    localparam int unsigned I2 = (i + 2) % NUM_AXES;

    logic signed [QW-1:0] a_nxt;
    logic signed [QW-1:0] b_nxt;
    logic signed [QW-1:0] c_nxt;
    logic signed [QW-1:0] d_nxt;
    logic signed [PW-1:0] p_nxt;
    logic signed [MW-1:0] e_nxt;
    logic signed [MW-1:0] f_nxt;
    logic signed [MW-1:0] g_nxt;
    logic signed [MW-1:0] h_nxt;
    logic signed [EW-1:0] s_nxt;
    logic signed [CW-1:0] rot_nxt;

    // For the x axis: px = qy*vz - qz*vy + qw*vx, and qx*vx feeds pw.
    always_comb begin
      a_nxt = q_in[I1] * v_in[I2];
      b_nxt = q_in[I2] * v_in[I1];
      c_nxt = in_quat_w * v_in[i];
      d_nxt = q_in[i] * v_in[i];
    end

    assign p_nxt = PW'(a_r[i]) - PW'(b_r[i]) + PW'(c_r[i]);

    // For the x axis: rx = pz*qy - py*qz + qw*px - pw*qx.
    always_comb begin
      e_nxt = p_r[I2] * q1_r[I1];
      f_nxt = p_r[I1] * q1_r[I2];
      g_nxt = p_r[i] * qw1_r;
      h_nxt = pw_r * q1_r[i];
    end

    assign s_nxt = EW'(e_r[i]) - EW'(f_r[i]) + EW'(g_r[i]) - EW'(h_r[i]) + HALF;

    qrv_round_sat #(
      .COMP_WIDTH (CW),
      .SUM_WIDTH  (EW),
      .SHIFT      (SHIFT)
    ) u_round_sat (
      .sum_i  (s_r[i]),
      .rot_o  (rot_nxt),
      .clip_o (clip_vec[i])
    );

    always_ff @(posedge clk) begin
      if (ld[0]) begin
        a_r[i]  <= a_nxt;
        b_r[i]  <= b_nxt;
        c_r[i]  <= c_nxt;
        d_r[i]  <= d_nxt;
        q0_r[i] <= q_in[i];
      end
      if (ld[1]) begin
        p_r[i]  <= p_nxt;
        q1_r[i] <= q0_r[i];
      end
      if (ld[2]) begin
        e_r[i] <= e_nxt;
        f_r[i] <= f_nxt;
        g_r[i] <= g_nxt;
        h_r[i] <= h_nxt;
      end
      if (ld[3]) begin
        s_r[i] <= s_nxt;
      end
      if (ld[4]) begin
        rot_r[i] <= rot_nxt;
      end
    end
  end

  // The scalar part of p is minus the dot product of q and v.
  assign pw_nxt = -(PW'(d_r[AX_X]) + PW'(d_r[AX_Y]) + PW'(d_r[AX_Z]));

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      qw0_r <= in_quat_w;
    end
    if (ld[1]) begin
      pw_r  <= pw_nxt;
      qw1_r <= qw0_r;
    end
    if (ld[4]) begin
      clip_r <= |clip_vec;
    end
  end

  assign out_rot_x   = rot_r[AX_X];
  assign out_rot_y   = rot_r[AX_Y];
  assign out_rot_z   = rot_r[AX_Z];
  assign out_clipped = clip_r;

endmodule

// ===== hdl/qrv_checker.sv =====
`include "quaternion_rotate_vector_assert.svh"

module qrv_checker
  import qrv_pkg::*;
#(
  parameter int unsigned COMP_WIDTH = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [COMP_WIDTH-1:0] out_rot_x,
  input logic signed [COMP_WIDTH-1:0] out_rot_y,
  input logic signed [COMP_WIDTH-1:0] out_rot_z,
  input logic                         out_clipped
);

  localparam int unsigned CNT_W = $clog2(NUM_STAGES + 1);

  // Items accepted at the input whose result has not yet been taken.
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_valid && in_ready && !(out_valid && out_ready)) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!(in_valid && in_ready) && out_valid && out_ready) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  `QRV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `QRV_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_rot_x) && $stable(out_rot_y) && $stable(out_rot_z) && $stable(out_clipped), "result changed while stalled")
  `QRV_ASSERT(a_no_phantom, out_valid, cnt_r != '0, "result shown with no item in flight")
  `QRV_ASSERT(a_room, cnt_r < CNT_W'(NUM_STAGES), in_ready, "input refused while a stage is free")
  `QRV_ASSERT_RST(a_reset_empty, !rst_n, !out_valid, "result shown straight after reset")

endmodule

bind quaternion_rotate_vector qrv_checker #(.COMP_WIDTH(COMP_WIDTH)) u_qrv_checker (.*);
